@@ rtl/pdhf_pkg.sv @@
// Shared types and constants for the path dedupe and heading filter.
// Pose payload structs, the job record between front and back, and the arctangent table.
// No dependencies.
`default_nettype none

package pdhf_pkg;

	localparam int POS_W  = 32;
	localparam int QUAT_W = 16;
	localparam int THR_W  = 24;
	localparam int CFG_W  = 32;
	localparam int ADDR_W = 3;

	localparam logic [ADDR_W-1:0] REG_THRESHOLD = 3'd0;
	localparam logic [THR_W-1:0]  THR_RESET     = 24'd3277;

	// CORDIC arithmetic widths
	localparam int ATAN_LEN = 24;
	localparam int NORM_W   = 49;   // normalized magnitude has its top bit at 48
	localparam int CV_W     = 52;   // vectoring x and y
	localparam int ANG_W    = 34;   // binary angles, 2^32 per turn
	localparam int ROT_W    = 34;   // rotation x and y, scaled by 2^30
	localparam int QSH      = 31 - QUAT_W;
	localparam logic [ANG_W-1:0] HALF_TURN    = 34'h0_8000_0000;
	localparam logic [ANG_W-1:0] QUARTER_TURN = 34'h0_4000_0000;
	localparam logic [ROT_W-1:0] CORDIC_X0    = 34'd652032874;
	localparam logic [QUAT_W-1:0] QUAT_LIM    = 16'h7fff;

	localparam logic [31:0] ATAN_TABLE [ATAN_LEN] = '{
		32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
		32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
		32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
		32'd166886,    32'd83443,     32'd41722,     32'd20861,
		32'd10430,     32'd5215,      32'd2608,      32'd1304,
		32'd652,       32'd326,       32'd163,       32'd81
	};

	localparam int QUEUE_DEPTH = 4;

	typedef logic [POS_W-1:0]  pos_t;
	typedef logic [QUAT_W-1:0] quat_t;

	typedef struct packed {
		pos_t  in_x;
		pos_t  in_y;
		pos_t  in_z;
		quat_t in_qx;
		quat_t in_qy;
		quat_t in_qz;
		quat_t in_qw;
		logic  in_last;
	} pose_in_t;

	typedef struct packed {
		pos_t  out_x;
		pos_t  out_y;
		pos_t  out_z;
		quat_t out_qx;
		quat_t out_qy;
		quat_t out_qz;
		quat_t out_qw;
		logic  out_last;
	} pose_out_t;

	typedef enum logic {
		JOB_PASS,
		JOB_HEAD
	} job_kind_t;

	// One pose to emit: either passed through, or given the heading toward (tx, ty).
	typedef struct packed {
		job_kind_t kind;
		pos_t      x;
		pos_t      y;
		pos_t      z;
		pos_t      tx;
		pos_t      ty;
		quat_t     qx;
		quat_t     qy;
		quat_t     qz;
		quat_t     qw;
		logic      last;
	} job_t;

endpackage

`default_nettype wire

@@ rtl/pdhf_queue.sv @@
// Short job queue between the front and back parts of the filter.
// Register-based FIFO of job_t records; depends on pdhf_pkg.
`default_nettype none

module pdhf_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          wr_valid,
	output logic               wr_ready,
	input  wire pdhf_pkg::job_t wr_job,
	output logic               rd_valid,
	input  wire logic          rd_ready,
	output pdhf_pkg::job_t     rd_job
);
	import pdhf_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	job_t             mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             do_wr;
	logic             do_rd;

	assign wr_ready = (count_q != (PTR_W+1)'(QUEUE_DEPTH));
	assign rd_valid = (count_q != '0);
	assign rd_job   = mem_q[rd_ptr_q];
	assign do_wr    = wr_valid && wr_ready;
	assign do_rd    = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/pdhf_front.sv @@
// Front part: accepts poses, merges near duplicates into the held pose and
// issues pass-through and heading jobs in stream order. Depends on pdhf_pkg.
`default_nettype none

module pdhf_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               item_valid,
	output logic                    item_ready,
	input  wire pdhf_pkg::pose_in_t item,
	input  wire logic [pdhf_pkg::THR_W-1:0]   threshold,
	input  wire logic [2*pdhf_pkg::THR_W-1:0] thr_sq,
	output logic                    job_valid,
	input  wire logic               job_ready,
	output pdhf_pkg::job_t          job
);
	import pdhf_pkg::*;

	// Stage 1 holds the raw item; stage 2 holds the squared distances.
	logic     v_s1_q;
	pose_in_t item_s1;
	logic     v_s2_q;
	pose_in_t item_s2;
	logic [2*THR_W-1:0] sqx_s2;
	logic [2*THR_W-1:0] sqy_s2;
	logic     over_s2;
	logic     phase_q;

	logic     held_valid_q;
	pose_in_t held_q;
	logic     pending_valid_q;
	pose_in_t pending_q;
	logic     owed_q;

	logic             adv1;
	logic [POS_W:0]   dx1;
	logic [POS_W:0]   dy1;
	logic [POS_W:0]   adx1;
	logic [POS_W:0]   ady1;
	logic             over1;

	logic [2*THR_W:0] dist_sq;
	logic             near;
	logic             hv;
	logic             mv;
	logic             pv1;
	pose_in_t         src_c;
	logic             last;
	logic [3:0]       pres;
	job_t             cand [4];
	job_t             job0;
	job_t             job1;
	logic [2:0]       cnt;
	logic [1:0]       n;
	logic             pushed;
	logic             done;

	function automatic job_t make_job(job_kind_t kind, pose_in_t src, pos_t tx, pos_t ty,
		logic lst);
		job_t j;
		j.kind = kind;
		j.x    = src.in_x;
		j.y    = src.in_y;
		j.z    = src.in_z;
		j.tx   = tx;
		j.ty   = ty;
		j.qx   = (kind == JOB_PASS) ? src.in_qx : '0;
		j.qy   = (kind == JOB_PASS) ? src.in_qy : '0;
		j.qz   = (kind == JOB_PASS) ? src.in_qz : '0;
		j.qw   = (kind == JOB_PASS) ? src.in_qw : '0;
		j.last = lst;
		return j;
	endfunction

	// The held pose only changes when stage 2 retires, so stage 1 waits for it.
	assign adv1       = v_s1_q && !v_s2_q;
	assign item_ready = !v_s1_q || adv1;

	always_comb begin
		dx1   = {item_s1.in_x[POS_W-1], item_s1.in_x} - {held_q.in_x[POS_W-1], held_q.in_x};
		dy1   = {item_s1.in_y[POS_W-1], item_s1.in_y} - {held_q.in_y[POS_W-1], held_q.in_y};
		adx1  = dx1[POS_W] ? (~dx1 + 1'b1) : dx1;
		ady1  = dy1[POS_W] ? (~dy1 + 1'b1) : dy1;
		over1 = (adx1 > {{(POS_W+1-THR_W){1'b0}}, threshold}) ||
			(ady1 > {{(POS_W+1-THR_W){1'b0}}, threshold});
	end

	always_comb begin
		dist_sq = {1'b0, sqx_s2} + {1'b0, sqy_s2};
		near    = !over_s2 && (dist_sq <= {1'b0, thr_sq});
		last    = item_s2.in_last;
		hv      = held_valid_q && !owed_q;
		mv      = hv && !near;
		pv1     = mv || pending_valid_q;
		src_c   = mv ? held_q : pending_q;

		pres[0] = owed_q;
		pres[1] = mv && pending_valid_q;
		pres[2] = last && pv1;
		pres[3] = last && ((2'(pres[0]) + 2'(pres[1]) + 2'(pres[2])) < 2'd2);

		cand[0] = make_job(JOB_PASS, held_q, '0, '0, 1'b1);
		cand[1] = make_job(JOB_HEAD, pending_q, held_q.in_x, held_q.in_y, 1'b0);
		cand[2] = make_job(JOB_HEAD, src_c, item_s2.in_x, item_s2.in_y, 1'b0);
		cand[3] = make_job(JOB_PASS, item_s2, '0, '0, 1'b1);

		job0 = '0;
		job1 = '0;
		cnt  = '0;
		for (int k = 0; k < 4; k++) begin
			if (pres[k]) begin
				if (cnt == 3'd0) begin
					job0 = cand[k];
				end else begin
					job1 = cand[k];
				end
				cnt = cnt + 3'd1;
			end
		end
		n = cnt[1:0];
	end

	assign job_valid = v_s2_q && ({1'b0, phase_q} < n);
	assign job       = phase_q ? job1 : job0;
	assign pushed    = job_valid && job_ready;
	assign done      = v_s2_q && ((n == 2'd0) || (pushed && ({1'b0, phase_q} == n - 2'd1)));

	always_ff @(posedge clk) begin
		if (item_valid && item_ready) begin
			item_s1 <= item;
		end
		if (adv1) begin
			item_s2 <= item_s1;
			sqx_s2  <= adx1[THR_W-1:0] * adx1[THR_W-1:0];
			sqy_s2  <= ady1[THR_W-1:0] * ady1[THR_W-1:0];
			over_s2 <= over1;
		end
		if (done) begin
			held_q <= item_s2;
			if (mv) begin
				pending_q <= held_q;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q          <= 1'b0;
			v_s2_q          <= 1'b0;
			phase_q         <= 1'b0;
			held_valid_q    <= 1'b0;
			pending_valid_q <= 1'b0;
			owed_q          <= 1'b0;
		end else begin
			if (item_valid && item_ready) begin
				v_s1_q <= 1'b1;
			end else if (adv1) begin
				v_s1_q <= 1'b0;
			end
			if (adv1) begin
				v_s2_q <= 1'b1;
			end else if (done) begin
				v_s2_q <= 1'b0;
			end
			if (done) begin
				phase_q         <= 1'b0;
				held_valid_q    <= !pres[3];
				pending_valid_q <= pv1 && !pres[2];
				// A final pose that did not fit goes out ahead of the next item.
				owed_q          <= last && !pres[3];
			end else if (pushed) begin
				phase_q <= 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

@@ rtl/pdhf_back.sv @@
// Back part: pipelined heading unit. Normalizes the pose-to-target vector, finds its
// angle by vectoring CORDIC, then sin and cos of the half angle by rotation CORDIC.
// Depends on pdhf_pkg.
`default_nettype none

module pdhf_back #(
	parameter int CORDIC_STEPS = 16
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           job_valid,
	output logic                job_ready,
	input  wire pdhf_pkg::job_t job,
	output logic                result_valid,
	input  wire logic           result_ready,
	output pdhf_pkg::pose_out_t result
);
	import pdhf_pkg::*;

	localparam int NRM = 6;
	localparam int S   = CORDIC_STEPS;

	typedef struct packed {
		logic  is_head;
		pos_t  x;
		pos_t  y;
		pos_t  z;
		quat_t qx;
		quat_t qy;
		quat_t qz;
		quat_t qw;
		logic  last;
		logic  neg_x;
		logic  neg_y;
		logic  zero;
	} carry_t;

	function automatic quat_t to_quat(logic signed [ROT_W-1:0] v);
		logic signed [ROT_W-1:0] r;
		logic signed [ROT_W-1:0] lim;
		lim = signed'({{(ROT_W-QUAT_W){1'b0}}, QUAT_LIM});
		r   = (v + signed'(ROT_W'(1) << (QSH-1))) >>> QSH;
		if (r > lim) begin
			r = lim;
		end else if (r < -lim) begin
			r = -lim;
		end
		return r[QUAT_W-1:0];
	endfunction

	logic en;

	logic                    v_nrm [0:NRM];
	carry_t                  c_nrm [0:NRM];
	logic [NORM_W-1:0]       nx    [0:NRM];
	logic [NORM_W-1:0]       ny    [0:NRM];

	logic                    v_vec [0:S];
	carry_t                  c_vec [0:S];
	logic signed [CV_W-1:0]  vx    [0:S];
	logic signed [CV_W-1:0]  vy    [0:S];
	logic signed [ANG_W-1:0] vz    [0:S];

	logic                    v_ang_q;
	carry_t                  c_ang_q;
	logic signed [ANG_W-1:0] h_ang_q;

	logic                    v_rot [0:S];
	carry_t                  c_rot [0:S];
	logic signed [ROT_W-1:0] rx    [0:S];
	logic signed [ROT_W-1:0] ry    [0:S];
	logic signed [ANG_W-1:0] rz    [0:S];

	logic [POS_W:0]          dx0;
	logic [POS_W:0]          dy0;
	carry_t                  c_in;
	logic [ANG_W-1:0]        zc;
	logic [ANG_W-1:0]        theta;
	logic [ANG_W-1:0]        half;
	pose_out_t               res_d;

	// The whole pipe moves together; it only holds while the output register is full.
	assign en        = !result_valid || result_ready;
	assign job_ready = en;

	always_comb begin
		dx0          = {job.tx[POS_W-1], job.tx} - {job.x[POS_W-1], job.x};
		dy0          = {job.ty[POS_W-1], job.ty} - {job.y[POS_W-1], job.y};
		c_in.is_head = (job.kind == JOB_HEAD);
		c_in.x       = job.x;
		c_in.y       = job.y;
		c_in.z       = job.z;
		c_in.qx      = job.qx;
		c_in.qy      = job.qy;
		c_in.qz      = job.qz;
		c_in.qw      = job.qw;
		c_in.last    = job.last;
		c_in.neg_x   = dx0[POS_W];
		c_in.neg_y   = dy0[POS_W];
		c_in.zero    = (dx0 == '0) && (dy0 == '0);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_nrm[0] <= c_in;
			nx[0]    <= {{(NORM_W-POS_W-1){1'b0}}, (dx0[POS_W] ? (~dx0 + 1'b1) : dx0)};
			ny[0]    <= {{(NORM_W-POS_W-1){1'b0}}, (dy0[POS_W] ? (~dy0 + 1'b1) : dy0)};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_nrm[0] <= 1'b0;
		end else if (en) begin
			v_nrm[0] <= job_valid;
		end
	end

	// Leading-zero normalization, one binary shift step per stage.
	for (genvar k = 0; k < NRM; k++) begin : g_nrm
		localparam int SH = 32 >> k;
		logic [NORM_W-1:0] both;
		logic              do_sh;
		assign both  = nx[k] | ny[k];
		assign do_sh = ((both >> (NORM_W - SH)) == '0);

		always_ff @(posedge clk) begin
			if (en) begin
				c_nrm[k+1] <= c_nrm[k];
				nx[k+1]    <= do_sh ? (nx[k] << SH) : nx[k];
				ny[k+1]    <= do_sh ? (ny[k] << SH) : ny[k];
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_nrm[k+1] <= 1'b0;
			end else if (en) begin
				v_nrm[k+1] <= v_nrm[k];
			end
		end
	end

	assign v_vec[0] = v_nrm[NRM];
	assign c_vec[0] = c_nrm[NRM];
	assign vx[0]    = signed'({{(CV_W-NORM_W){1'b0}}, nx[NRM]});
	assign vy[0]    = signed'({{(CV_W-NORM_W){1'b0}}, ny[NRM]});
	assign vz[0]    = '0;

	for (genvar i = 0; i < S; i++) begin : g_vec
		localparam logic signed [ANG_W-1:0] ATAN = signed'({2'b00, ATAN_TABLE[i]});
		always_ff @(posedge clk) begin
			if (en) begin
				c_vec[i+1] <= c_vec[i];
				if (!vy[i][CV_W-1]) begin
					vx[i+1] <= vx[i] + (vy[i] >>> i);
					vy[i+1] <= vy[i] - (vx[i] >>> i);
					vz[i+1] <= vz[i] + ATAN;
				end else begin
					vx[i+1] <= vx[i] - (vy[i] >>> i);
					vy[i+1] <= vy[i] + (vx[i] >>> i);
					vz[i+1] <= vz[i] - ATAN;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_vec[i+1] <= 1'b0;
			end else if (en) begin
				v_vec[i+1] <= v_vec[i];
			end
		end
	end

	// Clamp to the first quadrant, unfold by the signs, and halve.
	always_comb begin
		if (vz[S][ANG_W-1]) begin
			zc = '0;
		end else if (vz[S] > signed'(QUARTER_TURN)) begin
			zc = QUARTER_TURN;
		end else begin
			zc = vz[S];
		end
		if (c_vec[S].zero) begin
			theta = '0;
		end else if (c_vec[S].neg_x) begin
			theta = HALF_TURN - zc;
		end else begin
			theta = zc;
		end
		half = theta >> 1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_ang_q <= c_vec[S];
			h_ang_q <= c_vec[S].neg_y ? -signed'(half) : signed'(half);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_ang_q <= 1'b0;
		end else if (en) begin
			v_ang_q <= v_vec[S];
		end
	end

	assign v_rot[0] = v_ang_q;
	assign c_rot[0] = c_ang_q;
	assign rx[0]    = signed'(CORDIC_X0);
	assign ry[0]    = '0;
	assign rz[0]    = h_ang_q;

	for (genvar i = 0; i < S; i++) begin : g_rot
		localparam logic signed [ANG_W-1:0] ATAN = signed'({2'b00, ATAN_TABLE[i]});
		always_ff @(posedge clk) begin
			if (en) begin
				c_rot[i+1] <= c_rot[i];
				if (!rz[i][ANG_W-1]) begin
					rx[i+1] <= rx[i] - (ry[i] >>> i);
					ry[i+1] <= ry[i] + (rx[i] >>> i);
					rz[i+1] <= rz[i] - ATAN;
				end else begin
					rx[i+1] <= rx[i] + (ry[i] >>> i);
					ry[i+1] <= ry[i] - (rx[i] >>> i);
					rz[i+1] <= rz[i] + ATAN;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_rot[i+1] <= 1'b0;
			end else if (en) begin
				v_rot[i+1] <= v_rot[i];
			end
		end
	end

	always_comb begin
		res_d.out_x    = c_rot[S].x;
		res_d.out_y    = c_rot[S].y;
		res_d.out_z    = c_rot[S].z;
		res_d.out_last = c_rot[S].last;
		if (c_rot[S].is_head) begin
			res_d.out_qx = '0;
			res_d.out_qy = '0;
			res_d.out_qz = to_quat(ry[S]);
			res_d.out_qw = to_quat(rx[S]);
		end else begin
			res_d.out_qx = c_rot[S].qx;
			res_d.out_qy = c_rot[S].qy;
			res_d.out_qz = c_rot[S].qz;
			res_d.out_qw = c_rot[S].qw;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			result <= res_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (en) begin
			result_valid <= v_rot[S];
		end
	end

endmodule

`default_nettype wire

@@ rtl/path_dedupe_heading_filter.sv @@
// Path pose filter: merges near-duplicate poses and gives each surviving pose a
// yaw quaternion toward the next survivor. Depends on pdhf_pkg and the
// pdhf_front, pdhf_queue and pdhf_back modules.
//
// Poses enter on item (valid/ready) and filtered poses leave on result
// (valid/ready). The threshold register sits at APB address 0.
// The front part holds a pose in its first stage until the one before is decided:
// the held-pose compare is a loop through a squaring stage and a decide stage. A pose
// whose path ends right after a move can release two results, issued one after another.
// The back part is a stalling pipeline of 2*CORDIC_STEPS + 9 stages (41 at the
// default), and one result can leave per cycle while the receiver takes them.
// A result stays until it is taken; while the receiver stalls the pipeline
// holds, the queue fills, and then item_ready drops.
// When a path ends with three poses to release, the last one is held back and
// goes out ahead of anything caused by the next pose.
// Reset empties all stages, clears the held and pending poses and sets the
// threshold to 3277 (about 0.05 m).
`default_nettype none

module path_dedupe_heading_filter #(
	parameter int CORDIC_STEPS = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  item_valid,
	output logic                       item_ready,
	input  wire pdhf_pkg::pose_in_t    item,
	output logic                       result_valid,
	input  wire logic                  result_ready,
	output pdhf_pkg::pose_out_t        result,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [pdhf_pkg::ADDR_W-1:0] paddr,
	input  wire logic [pdhf_pkg::CFG_W-1:0]  pwdata,
	output logic [pdhf_pkg::CFG_W-1:0] prdata,
	output logic                       pready
);
	import pdhf_pkg::*;

	logic [THR_W-1:0]   threshold_q;
	logic [2*THR_W-1:0] thr_sq_q;

	logic fq_valid;
	logic fq_ready;
	job_t fq_job;
	logic qb_valid;
	logic qb_ready;
	job_t qb_job;

	assign pready = 1'b1;
	assign prdata = (paddr == REG_THRESHOLD) ? {{(CFG_W-THR_W){1'b0}}, threshold_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THR_RESET;
			thr_sq_q    <= THR_RESET * THR_RESET;
		end else begin
			if (psel && penable && pwrite && (paddr == REG_THRESHOLD)) begin
				threshold_q <= pwdata[THR_W-1:0];
			end
			thr_sq_q <= threshold_q * threshold_q;
		end
	end

	pdhf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.threshold  (threshold_q),
		.thr_sq     (thr_sq_q),
		.job_valid  (fq_valid),
		.job_ready  (fq_ready),
		.job        (fq_job)
	);

	pdhf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (fq_valid),
		.wr_ready (fq_ready),
		.wr_job   (fq_job),
		.rd_valid (qb_valid),
		.rd_ready (qb_ready),
		.rd_job   (qb_job)
	);

	pdhf_back #(
		.CORDIC_STEPS (CORDIC_STEPS)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.job_valid    (qb_valid),
		.job_ready    (qb_ready),
		.job          (qb_job),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule

`default_nettype wire

@@ dv/testbench.sv @@
// Testbench for path_dedupe_heading_filter: directed and random pose paths at several thresholds.
// Depends on pdhf_pkg and the RTL of the filter; a scoreboard class predicts every filtered pose.
`timescale 1ns / 100ps

import pdhf_pkg::*;

class pose_scoreboard;
	logic [THR_W-1:0] thr;
	bit held_v, pend_v;
	pose_in_t held, pend;
	pose_out_t exp_q[$];
	int errors, checked, accepted;

	function void clear();
		thr = THR_RESET;
		held_v = 0;
		pend_v = 0;
		held = '0;
		pend = '0;
	endfunction

	function longint sx(pos_t v);
		return longint'($signed(v));
	endfunction

	function longint mag(longint v);
		return (v < 0) ? -v : v;
	endfunction

	function bit near(pose_in_t a, pose_in_t b);
		longint mx, my, t;
		mx = mag(sx(a.in_x) - sx(b.in_x));
		my = mag(sx(a.in_y) - sx(b.in_y));
		t = longint'(thr);
		if (mx > t || my > t)
			return 0;
		return mx * mx + my * my <= t * t;
	endfunction

	function quat_t round_quat(longint v);
		longint r;
		r = (v + (64'sd1 << (QSH - 1))) >>> QSH;
		if (r > 32767)
			r = 32767;
		if (r < -32767)
			r = -32767;
		return quat_t'(r);
	endfunction

	function void half_heading(longint dx, longint dy, output quat_t qz, output quat_t qw);
		longint theta, x, y, z, h, nx;
		theta = 0;
		if (dx != 0 || dy != 0) begin
			x = mag(dx);
			y = mag(dy);
			while ((x > y ? x : y) < (64'sd1 << 48)) begin
				x = x <<< 1;
				y = y <<< 1;
			end
			z = 0;
			for (int i = 0; i < 16; i++) begin
				if (y >= 0) begin
					nx = x + (y >>> i);
					y = y - (x >>> i);
					z += longint'(ATAN_TABLE[i]);
				end else begin
					nx = x - (y >>> i);
					y = y + (x >>> i);
					z -= longint'(ATAN_TABLE[i]);
				end
				x = nx;
			end
			if (z < 0)
				z = 0;
			if (z > 64'sd1073741824)
				z = 64'sd1073741824;
			theta = (dx < 0) ? 64'sd2147483648 - z : z;
		end
		h = theta >>> 1;
		if (dy < 0)
			h = -h;
		x = 652032874;
		y = 0;
		z = h;
		for (int i = 0; i < 16; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i);
				y = y + (x >>> i);
				z -= longint'(ATAN_TABLE[i]);
			end else begin
				nx = x + (y >>> i);
				y = y - (x >>> i);
				z += longint'(ATAN_TABLE[i]);
			end
			x = nx;
		end
		qz = round_quat(y);
		qw = round_quat(x);
	endfunction

	function void queue_pose(pose_out_t o);
		exp_q = {exp_q, o};
	endfunction

	// The pending pose points at whatever is held at the moment it is released.
	function void release_pending();
		pose_out_t o;
		quat_t qz, qw;
		half_heading(sx(held.in_x) - sx(pend.in_x), sx(held.in_y) - sx(pend.in_y), qz, qw);
		o = '{pend.in_x, pend.in_y, pend.in_z, '0, '0, qz, qw, 1'b0};
		queue_pose(o);
	endfunction

	// A held-back final pose goes out before anything the next pose causes, so
	// queuing it at once keeps the same order.
	function void note_pose(pose_in_t p);
		accepted++;
		if (held_v && !near(held, p)) begin
			if (pend_v)
				release_pending();
			pend = held;
			pend_v = 1;
		end
		held = p;
		held_v = 1;
		if (p.in_last) begin
			if (pend_v)
				release_pending();
			pend_v = 0;
			queue_pose('{held.in_x, held.in_y, held.in_z, held.in_qx, held.in_qy,
				held.in_qz, held.in_qw, 1'b1});
			held_v = 0;
		end
	endfunction

	task report(string what);
		errors++;
		$display("%0t mismatch: %s", $realtime, what);
	endtask

	task check_result(pose_out_t r);
		pose_out_t e;
		checked++;
		if (exp_q.size() == 0) begin
			report($sformatf("unexpected pose %h", r));
			return;
		end
		e = exp_q.pop_front();
		if (r.out_x !== e.out_x) report($sformatf("x %h, want %h", r.out_x, e.out_x));
		if (r.out_y !== e.out_y) report($sformatf("y %h, want %h", r.out_y, e.out_y));
		if (r.out_z !== e.out_z) report($sformatf("z %h, want %h", r.out_z, e.out_z));
		if (r.out_qx !== e.out_qx) report($sformatf("qx %h, want %h", r.out_qx, e.out_qx));
		if (r.out_qy !== e.out_qy) report($sformatf("qy %h, want %h", r.out_qy, e.out_qy));
		if (r.out_qz !== e.out_qz) report($sformatf("qz %h, want %h", r.out_qz, e.out_qz));
		if (r.out_qw !== e.out_qw) report($sformatf("qw %h, want %h", r.out_qw, e.out_qw));
		if (r.out_last !== e.out_last) report($sformatf("last %b, want %b", r.out_last, e.out_last));
	endtask
endclass

module testbench;
	localparam int IDLE_LIMIT = 5000;

	logic clk, arst_n;
	logic item_valid, item_ready, result_valid, result_ready;
	pose_in_t item;
	pose_out_t result;
	logic psel, penable, pwrite, pready;
	logic [ADDR_W-1:0] paddr;
	logic [CFG_W-1:0] pwdata, prdata;

	pose_scoreboard sb = new();
	int burst_left, idle_cycles, hold_req, paths;
	pos_t cur_x, cur_y;

	path_dedupe_heading_filter dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.result_valid(result_valid), .result_ready(result_ready), .result(result),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	// Receiver: checks taken poses and stalls on its own pattern.
	always @(posedge clk) begin : receiver
		int stall_left, mode;
		if (arst_n && result_valid && result_ready)
			sb.check_result(result);
		if (hold_req != 0) begin
			stall_left = hold_req;
			hold_req = 0;
		end
		mode = (int'($time) / 4000) % 3;
		if (stall_left > 0) begin
			stall_left--;
			result_ready <= 1'b0;
		end else if (mode == 0)
			result_ready <= 1'b1;
		else
			result_ready <= ($urandom_range(0, 99) < (mode == 1 ? 75 : 30));
	end

	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready) || !arst_n)
			idle_cycles = 0;
		else if (++idle_cycles >= IDLE_LIMIT) begin
			$display("watchdog: no item moved for %0d cycles", IDLE_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// Called at a rising edge; returns when the item is accepted, or after a random pause if a burst ends there.
	task send_pose(pose_in_t p, bit stop);
		item_valid <= 1'b1;
		item <= p;
		do @(posedge clk); while (!item_ready);
		sb.note_pose(p);
		if (burst_left > 0)
			burst_left--;
		if (stop || burst_left == 0) begin
			item_valid <= 1'b0;
			if (!stop)
				repeat ($urandom_range(1, 15)) @(posedge clk);
			burst_left = ($urandom_range(0, 3) == 0) ? 40 : $urandom_range(1, 12);
		end
	endtask

	function pose_in_t mk_pose(pos_t x, pos_t y, bit last);
		pose_in_t p;
		p.in_x = x;
		p.in_y = y;
		p.in_z = $urandom;
		p.in_qx = quat_t'($urandom);
		p.in_qy = quat_t'($urandom);
		p.in_qz = quat_t'($urandom);
		p.in_qw = quat_t'($urandom);
		p.in_last = last;
		return p;
	endfunction

	task apb_cycle(bit wr, logic [CFG_W-1:0] data);
		psel <= 1'b1;
		pwrite <= wr;
		paddr <= REG_THRESHOLD;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (!wr && prdata[THR_W-1:0] !== sb.thr)
			sb.report($sformatf("threshold reads %h, want %h", prdata, sb.thr));
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task set_threshold(logic [CFG_W-1:0] v);
		apb_cycle(1'b1, v);
		sb.thr = v[THR_W-1:0];
		apb_cycle(1'b0, '0);
	endtask

	// A lone final pose leaves the filter with nothing held, then wait it out.
	task finish_phase();
		send_pose(mk_pose($urandom, $urandom, 1'b1), 1'b1);
		while (sb.exp_q.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task random_path();
		int len, kind;
		longint span;
		len = $urandom_range(1, 8);
		kind = $urandom_range(0, 9);
		if (kind == 0) begin
			cur_x = $urandom;
			cur_y = $urandom;
		end else begin
			cur_x = $urandom_range(0, 32'h01ff_ffff) - 32'h0100_0000;
			cur_y = $urandom_range(0, 32'h01ff_ffff) - 32'h0100_0000;
		end
		paths++;
		for (int i = 0; i < len; i++) begin
			if (kind == 0) begin
				cur_x = $urandom;
				cur_y = $urandom;
			end else if ($urandom_range(0, 9) < 4) begin
				span = sb.thr;
				cur_x = cur_x + pos_t'(longint'($urandom_range(32'(span), 0)) - span / 2);
				cur_y = cur_y + pos_t'(longint'($urandom_range(32'(span), 0)) - span / 2);
			end else begin
				cur_x += $urandom_range(0, 32'h003f_ffff) - 32'h0020_0000;
				cur_y += $urandom_range(0, 32'h003f_ffff) - 32'h0020_0000;
			end
			send_pose(mk_pose(cur_x, cur_y, i == len - 1), 1'b0);
		end
	endtask

	initial begin
		logic [CFG_W-1:0] thr_set[5];
		pose_in_t p;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		result_ready = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		hold_req = 0;
		burst_left = 4;
		sb.clear();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		apb_cycle(1'b0, '0);

		// Single pose at the extremes passes through unchanged.
		p = '{32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 16'h8000, 16'h7fff,
			16'h8000, 16'h0001, 1'b1};
		send_pose(p, 1'b0);
		// Coincident duplicate, a step straight back, then a last move: three due.
		send_pose(mk_pose(32'd0, 32'd0, 1'b0), 1'b0);
		send_pose(mk_pose(32'd0, 32'd0, 1'b0), 1'b0);
		send_pose(mk_pose(-32'sd65536, 32'd0, 1'b0), 1'b0);
		send_pose(mk_pose(-32'sd65536, -32'sd65536, 1'b1), 1'b0);
		// Held-back final goes out ahead of this path's poses.
		send_pose(mk_pose(32'h8000_0000, 32'd5, 1'b0), 1'b0);
		send_pose(mk_pose(32'h7fff_ffff, 32'd5, 1'b0), 1'b0);
		send_pose(mk_pose(32'h7fff_ffff, 32'h8000_0000, 1'b0), 1'b0);
		send_pose(mk_pose(32'h0000_0000, 32'h7fff_ffff, 1'b1), 1'b0);
		// Exactly at the threshold merges, one past it does not.
		send_pose(mk_pose(32'd0, 32'd0, 1'b0), 1'b0);
		send_pose(mk_pose(32'd3277, 32'd0, 1'b0), 1'b0);
		send_pose(mk_pose(32'd6555, 32'd0, 1'b0), 1'b0);
		send_pose(mk_pose(32'd6555, 32'd3277, 1'b0), 1'b0);
		send_pose(mk_pose(32'd8872, 32'd5594, 1'b0), 1'b0);
		send_pose(mk_pose(32'd8000, -32'sd100000, 1'b1), 1'b0);
		finish_phase();

		thr_set = '{32'd0, 32'hff_ffff, 32'hffff_ffff, 32'd65536, $urandom_range(1, 32'hff_ffff)};
		foreach (thr_set[k]) begin
			int goal;
			set_threshold(thr_set[k]);
			goal = sb.accepted + 105;
			// One long receiver stall while poses keep coming fills the block.
			if (k == 1)
				hold_req = 400;
			while (sb.accepted < goal)
				random_path();
			finish_phase();
		end

		$display("Covered %0d poses in %0d random paths over %0d thresholds; %0d poses checked.",
			sb.accepted, paths, $size(thr_set) + 1, sb.checked);
		if (sb.errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule
